>>> src/nbc_pkg.sv
// ----------------------------------------------------------------------------
// nbc_pkg: shared types and constants for the negative base converter
// Field widths, digit limits and derived counter widths.
// ----------------------------------------------------------------------------
package nbc_pkg;

	localparam int VALUE_BITS = 60;
	localparam int RADIX_BITS = 11;
	localparam int MAX_DIGITS = 61;
	localparam int POS_BITS   = 6;
	localparam int STEP_BITS  = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [RADIX_BITS-1:0] radix_t;
	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [STEP_BITS-1:0]  step_t;

endpackage

>>> src/nbc_if.sv
// ----------------------------------------------------------------------------
// nbc_if: channel interfaces of the negative base converter
// Valid/ready channels for the input value, the digit stream and the radix.
// ----------------------------------------------------------------------------
interface nbc_in_if;
	logic            valid;
	logic            ready;
	nbc_pkg::value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface nbc_out_if;
	logic            valid;
	logic            ready;
	nbc_pkg::radix_t digit;
	nbc_pkg::pos_t   digit_position;
	logic            last;

	modport source (output valid, output digit, output digit_position, output last,
		input ready);
	modport sink   (input valid, input digit, input digit_position, input last,
		output ready);
endinterface

interface nbc_cfg_if;
	logic            valid;
	logic            ready;
	nbc_pkg::radix_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/negative_base_converter.sv
// ----------------------------------------------------------------------------
// negative_base_converter: writes a non-negative value in base minus k
// Shared restoring divider under a small sequencer, one digit per pass.
// ----------------------------------------------------------------------------
// Channels: req takes one value per beat, rsp gives one digit per beat, least
// significant first, with last on the most significant digit; cfg writes the
// radix magnitude k (0 and 1 act as 2); the user must write it only while the
// block is idle, as the block does not enforce this. Each digit costs one pass
// of a bit-serial restoring divider: a shift/subtract step for each of the
// VALUE_BITS (60) value bits, then a fold step.
// req.ready is high only between conversions; the next value is taken while
// the final digit may still sit in the output register.
// A stalled receiver holds the sequencer in its fold cycle; no digit is lost.
// Reset (arst_n low) drops any conversion in flight, empties the output
// register and sets k back to 2.
// Working value sign alternates with the digit position, so only its
// magnitude is kept: even positions are non-negative, odd ones non-positive.
// ----------------------------------------------------------------------------
module negative_base_converter (
	input  logic             clk,
	input  logic             arst_n,
	nbc_in_if.sink           req,
	nbc_out_if.source        rsp,
	nbc_cfg_if.sink          cfg
);
	import nbc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FOLD = 2'd2;

	logic [1:0] state_q;
	radix_t     radix_q;
	value_t     mag_q;
	radix_t     rem_q;
	step_t      step_q;
	pos_t       pos_q;

	logic       out_valid_q;
	radix_t     out_digit_q;
	pos_t       out_pos_q;
	logic       out_last_q;

	radix_t                k_eff;
	logic [RADIX_BITS:0]   trial;
	logic [RADIX_BITS:0]   k_ext;
	logic                  ge;
	radix_t                rem_next;
	value_t                quo_inc;
	value_t                mag_fold;
	radix_t                digit_fold;
	logic                  done_fold;
	logic                  slot_free;
	logic                  fold_fire;

	assign k_eff = (radix_q < radix_t'(2)) ? radix_t'(2) : radix_q;

	// divider step: bring in the next value bit, subtract k when it fits
	assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
	assign k_ext    = {1'b0, k_eff};
	assign ge       = (trial >= k_ext);
	assign rem_next = ge ? radix_t'(trial - k_ext) : trial[RADIX_BITS-1:0];

	// fold: on odd positions the value is negative, so round the quotient up
	assign quo_inc = mag_q + value_t'(1);
	always_comb begin
		if (pos_q[0] && (rem_q != '0)) begin
			digit_fold = k_eff - rem_q;
			mag_fold   = quo_inc;
		end else begin
			digit_fold = rem_q;
			mag_fold   = mag_q;
		end
	end
	assign done_fold = (mag_fold == '0) || (pos_q == pos_t'(MAX_DIGITS - 1));
	assign slot_free = !out_valid_q || rsp.ready;
	assign fold_fire = (state_q == ST_FOLD) && slot_free;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid          = out_valid_q;
	assign rsp.digit          = out_digit_q;
	assign rsp.digit_position = out_pos_q;
	assign rsp.last           = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= radix_t'(2);
			mag_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_digit_q <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
			step_q      <= '0;
			pos_q       <= '0;
		end else begin
			if (cfg.valid)
				radix_q <= cfg.data;
			if (fold_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mag_q   <= req.value;
						rem_q   <= '0;
						step_q  <= '0;
						pos_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					mag_q <= {mag_q[VALUE_BITS-2:0], ge};
					rem_q <= rem_next;
					if (step_q == step_t'(VALUE_BITS - 1)) begin
						step_q  <= '0;
						state_q <= ST_FOLD;
					end else begin
						step_q <= step_q + step_t'(1);
					end
				end
				ST_FOLD: begin
					// hold until the output register can take the beat
					if (slot_free) begin
						out_digit_q <= digit_fold;
						out_pos_q   <= pos_q;
						out_last_q  <= done_fold;
						mag_q       <= mag_fold;
						rem_q       <= '0;
						pos_q       <= pos_q + pos_t'(1);
						state_q     <= done_fold ? ST_IDLE : ST_DIV;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> test/tb_negative_base_converter.sv
// ----------------------------------------------------------------------------
// tb_negative_base_converter: self-checking bench for the negative base converter
// Sends values over req, programs k over cfg between phases and checks every
// digit beat on rsp against a behavioral base minus k expansion (typed rows:
// one given digit), with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_negative_base_converter;

	import nbc_pkg::*;

	localparam int QUIET_LIMIT = 5000; // cycles with no beat on any channel
	localparam int DRAIN_WAIT  = 400;  // idle wait after the final drain
	localparam int HOLD_CYCLES = 500;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 15;
	localparam int REPORT_MAX  = 10;

	typedef enum logic [1:0] {ROW_CFG, ROW_CONVERT, ROW_CONVERT_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		radix_t    radix;
		value_t    value;
		radix_t    typed_digit; // single expected digit for typed rows
	} stim_row_t;

	typedef struct packed {
		radix_t digit;
		pos_t   pos;
		logic   last;
	} digit_beat_t;

	localparam int N_ROWS = 21;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_CONVERT_TYPED, 11'd0,    60'd0,                  11'd0},
		'{ROW_CONVERT_TYPED, 11'd0,    60'd1,                  11'd1},
		'{ROW_CONVERT,       11'd0,    60'd2,                  11'd0},
		'{ROW_CONVERT,       11'd0,    60'hFFF_FFFF_FFFF_FFFF, 11'd0},
		'{ROW_CONVERT,       11'd0,    60'hAAA_AAAA_AAAA_AAAA, 11'd0},
		'{ROW_CFG,           11'd0,    60'd0,                  11'd0},
		'{ROW_CONVERT,       11'd0,    60'd3,                  11'd0},
		'{ROW_CFG,           11'd1,    60'd0,                  11'd0},
		'{ROW_CONVERT,       11'd0,    60'h800_0000_0000_0000, 11'd0},
		'{ROW_CFG,           11'd2000, 60'd0,                  11'd0},
		'{ROW_CONVERT_TYPED, 11'd0,    60'd1999,               11'd1999},
		'{ROW_CONVERT,       11'd0,    60'd2000,               11'd0},
		'{ROW_CONVERT,       11'd0,    60'hFFF_FFFF_FFFF_FFFF, 11'd0},
		'{ROW_CONVERT_TYPED, 11'd0,    60'd0,                  11'd0},
		'{ROW_CFG,           11'd2047, 60'd0,                  11'd0},
		'{ROW_CONVERT_TYPED, 11'd0,    60'd2046,               11'd2046},
		'{ROW_CONVERT,       11'd0,    60'hFFF_FFFF_FFFF_FFFF, 11'd0},
		'{ROW_CONVERT,       11'd0,    60'h555_5555_5555_5555, 11'd0},
		'{ROW_CFG,           11'd3,    60'd0,                  11'd0},
		'{ROW_CONVERT,       11'd0,    60'hFFF_FFFF_FFFF_FFFF, 11'd0},
		'{ROW_CONVERT_TYPED, 11'd0,    60'd1,                  11'd1}
	};

	logic clk;
	logic arst_n;

	nbc_in_if  req_ch ();
	nbc_out_if rsp_ch ();
	nbc_cfg_if cfg_ch ();

	negative_base_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	radix_t      radix_shadow;
	digit_beat_t pending_digits[$];
	int          mismatch_count;
	int          quiet_cycles;
	bit          watchdog_on;
	bit          no_idle;
	bit          pressure_req;
	bit          pressure_done;
	int          hold_left;
	int          stall_left;

	always #2 clk = ~clk;

	// Expand v in base minus k and queue one beat per digit.
	function automatic void queue_neg_base_digits(value_t v);
		longint k;
		longint w;
		longint rem;
		longint quo;
		int     cnt;
		bit     done;
		digit_beat_t b;
		k = (radix_shadow < 2) ? 64'sd2 : longint'(radix_shadow);
		w = longint'(v);
		cnt = 0;
		do begin
			rem = w % k;
			if (rem < 0) rem += k;
			quo = (w - rem) / k;
			w = -quo;
			done = (w == 0) || (cnt + 1 >= MAX_DIGITS);
			b.digit = radix_t'(rem);
			b.pos = pos_t'(cnt);
			b.last = done;
			pending_digits.push_back(b);
			cnt++;
		end while (!done);
	endfunction

	function automatic value_t random_value();
		int     width;
		value_t raw;
		width = $urandom_range(1, VALUE_BITS);
		raw = value_t'({$urandom, $urandom});
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return raw & (value_t'('1) >> (VALUE_BITS - width));
		endcase
	endfunction

	// Entered and left at a falling edge; valid is left high for the caller.
	task automatic send_value(value_t v, bit use_typed, radix_t typed_digit);
		digit_beat_t b;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		if (use_typed) begin
			b.digit = typed_digit;
			b.pos = '0;
			b.last = 1'b1;
			pending_digits.push_back(b);
		end else begin
			queue_neg_base_digits(v);
		end
		@(negedge clk);
	endtask

	// Drop valid and wait until every queued digit has come out.
	task automatic drain_digits();
		req_ch.valid <= 1'b0;
		while (pending_digits.size() != 0) @(negedge clk);
	endtask

	task automatic write_radix(radix_t r);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= r;
		do @(posedge clk); while (!cfg_ch.ready);
		radix_shadow = r;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic report_mismatch(string what, digit_beat_t exp_b, digit_beat_t got_b);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("MISMATCH %s: expected digit %0d pos %0d last %0d, got digit %0d pos %0d last %0d",
				what, exp_b.digit, exp_b.pos, exp_b.last, got_b.digit, got_b.pos, got_b.last);
	endtask

	// Digit checker.
	always @(posedge clk) begin
		digit_beat_t got_b;
		digit_beat_t exp_b;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_b.digit = rsp_ch.digit;
			got_b.pos = rsp_ch.digit_position;
			got_b.last = rsp_ch.last;
			if (pending_digits.size() == 0) begin
				exp_b = '0;
				report_mismatch("unexpected beat", exp_b, got_b);
			end else begin
				exp_b = pending_digits.pop_front();
				if (got_b !== exp_b) report_mismatch("digit beat", exp_b, got_b);
			end
		end
	end

	// Receiver: random stall bursts plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pressure_req && !pressure_done) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (watchdog_on) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("negative_base_converter test failed");
				$finish;
			end
		end
	end

	initial begin
		radix_t phase_radix;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		radix_shadow = radix_t'(2);
		mismatch_count = 0;
		quiet_cycles = 0;
		watchdog_on = 1'b0;
		no_idle = 1'b0;
		pressure_req = 1'b0;
		pressure_done = 1'b0;
		hold_left = 0;
		stall_left = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		watchdog_on = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			case (DIRECTED[i].kind)
				ROW_CFG: begin
					drain_digits();
					write_radix(DIRECTED[i].radix);
				end
				ROW_CONVERT_TYPED: send_value(DIRECTED[i].value, 1'b1, DIRECTED[i].typed_digit);
				default: send_value(DIRECTED[i].value, 1'b0, '0);
			endcase
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: phase_radix = radix_t'(2);
				1: phase_radix = radix_t'(2000);
				2: phase_radix = radix_t'(5);
				3: phase_radix = radix_t'(0);
				4: phase_radix = radix_t'(2047);
				5: phase_radix = radix_t'(1);
				6: phase_radix = radix_t'($urandom_range(2001, 2047));
				default: phase_radix = radix_t'($urandom_range(2, 2000));
			endcase
			drain_digits();
			// Last phase runs with both sides always willing.
			if (ph == N_PHASES - 1) no_idle = 1'b1;
			write_radix(phase_radix);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 3) pressure_req = 1'b1;
				send_value(random_value(), 1'b0, '0);
			end
		end

		drain_digits();
		watchdog_on = 1'b0;
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatch_count == 0 && pending_digits.size() == 0)
			$display("negative_base_converter test passed");
		else
			$display("negative_base_converter test failed");
		$finish;
	end

endmodule
